// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int COUNT_W = 16;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;

    localparam logic [CHAR_W-1:0]  NL_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0]  CR_CODE     = 8'd13;
    localparam logic [ATTR_W-1:0]  ATTR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0]  BLANK_RESET = 16'd3872;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    // Configuration register indexes
    localparam logic CFG_TEXT_ATTR  = 1'b0;
    localparam logic CFG_BLANK_CELL = 1'b1;

    // Item kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cursor;

    typedef struct packed {
        t_cursor            pos;
        logic [COUNT_W-1:0] count;
        logic               scrolled;
    } t_put_res;

    typedef struct packed {
        t_cursor            pos;
        logic [CELL_W-1:0]  cell_data;
        logic [COUNT_W-1:0] count;
        logic               scrolled;
    } t_result;

endpackage

// File: rtl/tcw_cell_ram.sv
// Single-port-write, registered-read cell memory.
module tcw_cell_ram import tcw_pkg::*; #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tcw_cursor.sv
// Cursor position, linear cell address and string counter.
module tcw_cursor import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_put,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output t_cursor           o_cur,
    output t_put_res          o_put,
    output logic [AW-1:0]     o_wr_addr,
    output logic              o_printable,
    output logic              o_scroll
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_base, n_base;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [CW:0]        col_inc;
    logic               row_adv;
    logic [COUNT_W-1:0] count_inc;

    always_comb begin
        col_inc   = {1'b0, r_col} + 1'b1;
        count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        o_printable = (i_char != NL_CODE) && (i_char != CR_CODE);
        n_col   = '0;
        row_adv = 1'b0;
        if (i_char == NL_CODE) begin
            row_adv = 1'b1;
        end else if (o_printable) begin
            if (col_inc == (CW+1)'(COLUMNS)) begin
                row_adv = 1'b1;
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
        o_scroll = row_adv && (r_row == RW'(ROWS - 1));
        n_row  = r_row;
        n_base = r_base;
        if (row_adv && !o_scroll) begin
            n_row  = r_row + 1'b1;
            n_base = r_base + AW'(COLUMNS);
        end
        n_count = i_last ? '0 : count_inc;

        o_put.pos.row = ROW_W'(n_row);
        o_put.pos.col = COL_W'(n_col);
        o_put.count   = i_last ? count_inc : '0;
        o_put.scrolled = o_scroll;
    end

    assign o_wr_addr = r_base + AW'(r_col);
    assign o_cur.row = ROW_W'(r_row);
    assign o_cur.col = COL_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_base  <= '0;
            r_count <= '0;
        end else if (i_put) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/text_console_writer_core.sv
// Top level of the text console writer: sequencer, cell store and result stage.
//
// Use: the console owns a ROWS x COLUMNS store of 16-bit cells.
// Input channel (i_in_valid / o_in_stall) carries one item per transaction:
// a put (i_kind = 0) of one character, or a read (i_kind = 1) of the cell
// at i_cell_index. Every item yields one result transaction on the output
// channel (o_out_valid / i_out_stall) with the cursor after the item.
// Newline and carriage return move the cursor; other bytes are stored as
// attribute<<8 | char. Cursor past the last row scrolls the store.
// A put's result passes through the result holding register and then the
// output register; a read's result first passes the registered read of the
// cell memory. The input takes no new item until the last result has left
// the holding register. A put that scrolls copies the store one cell per
// cycle through the memory's single write port and then fills the bottom row
// with the blank cell; the input stays stalled until that is done.
// Reset: cursor, string count and configuration registers return to their
// reset values; the store is then cleared to zero by a pass over every cell
// during which input stays stalled. Configuration writes are taken at any
// time through i_cfg_valid / o_cfg_ready.
// Stall: a finished result waits in a holding register while the output
// register is stalled; input is stalled until that result moves on.
module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CELL_W-1:0]  i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_last,
    input  logic [INDEX_W-1:0] i_cell_index,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ROW_W-1:0]   o_cursor_row,
    output logic [COL_W-1:0]   o_cursor_col,
    output logic [CELL_W-1:0]  o_cell_data,
    output logic [COUNT_W-1:0] o_written_count,
    output logic               o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_FILL   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic               r_cp_valid;
    logic [AW-1:0]      r_cp_addr;
    logic               r_rd_ok;
    logic               r_pend, n_pend;
    t_result            r_res, n_res;
    t_result            r_out;
    logic               r_out_valid;
    logic [ATTR_W-1:0]  r_attr;
    logic [CELL_W-1:0]  r_blank;

    logic               in_take;
    logic               put_take;
    logic               out_free;

    t_cursor            cur;
    t_put_res           put_res;
    logic [AW-1:0]      cur_addr;
    logic               printable;
    logic               scroll;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;

    // Configuration registers: always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= ATTR_RESET;
            r_blank <= BLANK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEXT_ATTR:  r_attr  <= i_cfg_data[ATTR_W-1:0];
                CFG_BLANK_CELL: r_blank <= i_cfg_data;
                default:        r_blank <= r_blank;
            endcase
        end
    end

    // Take a new item only when idle and no result is held.
    assign o_in_stall = !((r_state == ST_IDLE) && !r_pend);
    assign in_take    = i_in_valid && !o_in_stall;
    assign put_take   = in_take && (i_kind == KIND_PUT);
    assign out_free   = !r_out_valid || !i_out_stall;

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_put       (put_take),
        .i_char      (i_char_code),
        .i_last      (i_last),
        .o_cur       (cur),
        .o_put       (put_res),
        .o_wr_addr   (cur_addr),
        .o_printable (printable),
        .o_scroll    (scroll)
    );

    // Write port: a pending scroll copy wins; otherwise clear, fill or put.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = '0;
        if (r_cp_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_cp_addr;
            mem_wdata = mem_rdata;
        end else if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
        end else if (r_state == ST_FILL) begin
            mem_we    = 1'b1;
            mem_wdata = r_blank;
        end else if (put_take && printable) begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {r_attr, i_char_code};
        end
    end

    // Read port: the source cell during a scroll, else the requested cell.
    assign mem_raddr = (r_state == ST_SCROLL) ? r_ptr : AW'(i_cell_index);

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_pend  = r_pend;
        n_res   = r_res;
        if (r_pend && out_free) begin
            n_pend = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    if (i_kind == KIND_READ) begin
                        n_res.pos       = cur;
                        n_res.cell_data = '0;
                        n_res.count     = '0;
                        n_res.scrolled  = 1'b0;
                        n_state         = ST_READ;
                    end else begin
                        n_res.pos       = put_res.pos;
                        n_res.cell_data = '0;
                        n_res.count     = put_res.count;
                        n_res.scrolled  = put_res.scrolled;
                        if (scroll) begin
                            n_ptr   = AW'(COLUMNS);
                            n_state = ST_SCROLL;
                        end else begin
                            n_pend  = 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                n_res.cell_data = r_rd_ok ? mem_rdata : '0;
                n_pend          = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCROLL: begin
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_ptr   = AW'(CELLS - COLUMNS);
                    n_state = ST_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_FILL: begin
                // Hold the fill while the last copy drains.
                if (!r_cp_valid) begin
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr == AW'(CELLS - 1)) begin
                        n_pend  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_ptr      <= '0;
            r_pend     <= 1'b0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_pend     <= n_pend;
            r_cp_valid <= (r_state == ST_SCROLL);
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_cp_addr <= r_ptr - AW'(COLUMNS);
        if (in_take) begin
            r_rd_ok <= (32'(i_cell_index) < CELLS);
        end
    end

    // Output register: load the held result when the register frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_row    = r_out.pos.row;
    assign o_cursor_col    = r_out.pos.col;
    assign o_cell_data     = r_out.cell_data;
    assign o_written_count = r_out.count;
    assign o_scrolled      = r_out.scrolled;

    // A held result only exists while the sequencer is idle.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_IDLE))
        else $error("result held outside idle");

    // A copy write always follows a scroll read in the cycle before it.
    a_copy_after_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> ($past(r_state) == ST_SCROLL))
        else $error("copy write without scroll read");

    // After a scroll the cursor sits at column zero.
    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_cursor_col == '0))
        else $error("scroll left cursor off column zero");

    // Reads never report a scroll or a string count.
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_res.scrolled == 1'b0 && r_res.count == '0))
        else $error("read result carries put status");

endmodule

// File: verif/tb_text_console_writer_core.sv
// Self-checking testbench for the text console writer core.
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_TOTAL = ROWS * COLUMNS;
    localparam int CLK_PERIOD = 12;
    // Far above the slowest legal run: every item a full scroll, both sides
    // idling their longest, plus the clearing pass after reset.
    localparam int unsigned LIMIT_CYCLES = 20_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [CELL_W-1:0]  i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [CHAR_W-1:0]  i_char_code;
    logic               i_last;
    logic [INDEX_W-1:0] i_cell_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [ROW_W-1:0]   o_cursor_row;
    logic [COL_W-1:0]   o_cursor_col;
    logic [CELL_W-1:0]  o_cell_data;
    logic [COUNT_W-1:0] o_written_count;
    logic               o_scrolled;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_last          (i_last),
        .i_cell_index    (i_cell_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_cell_data     (o_cell_data),
        .o_written_count (o_written_count),
        .o_scrolled      (o_scrolled)
    );

    // Shadow of the console: screen contents, cursor, running string length
    // and the two registers. Updated at the edge where a transaction is taken.
    logic [CELL_W-1:0]  screen_model [0:CELL_TOTAL-1];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COUNT_W-1:0] run_count;
    logic [ATTR_W-1:0]  attr_reg;
    logic [CELL_W-1:0]  blank_reg;

    t_result     pending_results [$];
    int unsigned mismatch_count;
    bit          idle_on;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: end the run if the handshakes ever hang.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("text_console_writer_core regression: fail");
        $finish;
    end

    // Advance the shadow console by one accepted item and return the result
    // it must produce.
    function automatic t_result console_predict(input logic kind,
                                                input logic [CHAR_W-1:0] ch,
                                                input logic last,
                                                input logic [INDEX_W-1:0] idx);
        t_result r;
        int      i;
        r = '0;
        if (kind == KIND_READ) begin
            // Out-of-range reads return zero
            if (idx < CELL_TOTAL)
                r.cell_data = screen_model[idx];
        end else begin
            if (ch == NL_CODE) begin
                cur_row++;
                cur_col = 0;
            end else if (ch == CR_CODE) begin
                cur_col = 0;
            end else begin
                screen_model[cur_row * COLUMNS + cur_col] = {attr_reg, ch};
                cur_col++;
            end
            // Wrap past the last column
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            // Scroll past the last row: shift up, fill the bottom row
            if (cur_row >= ROWS) begin
                for (i = 0; i < CELL_TOTAL - COLUMNS; i++)
                    screen_model[i] = screen_model[i + COLUMNS];
                for (i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++)
                    screen_model[i] = blank_reg;
                cur_row    = ROWS - 1;
                r.scrolled = 1'b1;
            end
            if (run_count < COUNT_MAX)
                run_count++;
            // Report the string length on its last character and restart it
            if (last) begin
                r.count   = run_count;
                run_count = '0;
            end
        end
        r.pos.row = ROW_W'(cur_row);
        r.pos.col = COL_W'(cur_col);
        return r;
    endfunction

    // Present one item after a random gap and hold it until it is taken.
    // Valid stays high into the next call when no gap is drawn.
    task automatic send_console_item(input logic kind, input logic [CHAR_W-1:0] ch,
                                     input logic last, input logic [INDEX_W-1:0] idx);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_char_code  <= ch;
        i_last       <= last;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(console_predict(kind, ch, last, idx));
    endtask

    // Drop input valid and hold off until every expected result is back.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [CELL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_TEXT_ATTR)
            attr_reg = data[ATTR_W-1:0];
        else
            blank_reg = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Fresh store: the first and last cells read zero, out-of-range reads too.
    task automatic test_power_on_store();
        send_console_item(KIND_READ, 8'h00, 1'b0, 11'd0);
        send_console_item(KIND_READ, 8'hFF, 1'b1, INDEX_W'(CELL_TOTAL - 1));
        send_console_item(KIND_READ, 8'h00, 1'b0, INDEX_W'(CELL_TOTAL));
        send_console_item(KIND_READ, 8'hFF, 1'b1, 11'h7FF);
    endtask

    // Extreme bytes, carriage return and newline inside one string, then
    // read back what landed in the store.
    task automatic test_control_chars();
        send_console_item(KIND_PUT, 8'h00, 1'b0, 11'h7FF);
        send_console_item(KIND_PUT, 8'hFF, 1'b0, 11'd0);
        send_console_item(KIND_PUT, CR_CODE, 1'b0, 11'd0);
        send_console_item(KIND_PUT, 8'h41, 1'b0, 11'd0);
        send_console_item(KIND_PUT, NL_CODE, 1'b1, 11'd0);
        send_console_item(KIND_PUT, CR_CODE, 1'b1, 11'd0);
        send_console_item(KIND_READ, 8'h00, 1'b0, 11'd0);
        send_console_item(KIND_READ, 8'h00, 1'b0, 11'd1);
        send_console_item(KIND_READ, 8'h00, 1'b0, INDEX_W'(COLUMNS));
    endtask

    // Random text: mostly well-formed strings with reads mixed in, some runs
    // of line breaks to force scrolls, some long lines to force wraps, and a
    // little noise that may leave a string open.
    task automatic test_text_phase(input bit reprogram, input logic [ATTR_W-1:0] attr,
                                   input logic [CELL_W-1:0] blank, input bit idling,
                                   input int unsigned item_goal);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int unsigned shape;
        int unsigned pick;
        int unsigned spot;
        logic [CHAR_W-1:0] ch;
        if (reprogram) begin
            wait_quiet();
            write_register(CFG_TEXT_ATTR, {{(CELL_W - ATTR_W){1'b0}}, attr});
            write_register(CFG_BLANK_CELL, blank);
        end
        idle_on = idling;
        sent = 0;
        while (sent < item_goal) begin
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                send_console_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, 2047)));
                sent++;
            end else begin
                case (shape)
                    1, 2:    len = $urandom_range(1, 6);
                    3:       len = $urandom_range(60, 140);
                    default: len = $urandom_range(1, 24);
                endcase
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        // Read near the cursor, anywhere, or past the store
                        pick = $urandom_range(0, 7);
                        if (pick == 0)
                            spot = $urandom_range(CELL_TOTAL, 2047);
                        else if (pick < 3)
                            spot = cur_row * COLUMNS + ((cur_col == 0) ? 0 : cur_col - 1);
                        else
                            spot = $urandom_range(0, CELL_TOTAL - 1);
                        send_console_item(KIND_READ, CHAR_W'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1)), INDEX_W'(spot));
                        sent++;
                    end
                    pick = $urandom_range(0, 31);
                    if (shape <= 2)
                        ch = (pick < 24) ? NL_CODE : CR_CODE;
                    else if (pick < 2)
                        ch = NL_CODE;
                    else if (pick == 2)
                        ch = CR_CODE;
                    else
                        ch = CHAR_W'($urandom_range(0, 255));
                    send_console_item(KIND_PUT, ch, k == len - 1,
                                      INDEX_W'($urandom_range(0, 2047)));
                    sent++;
                end
            end
        end
    endtask

    // Receiver: while idling is on, stall a random number of cycles before each
    // result, then take it.
    initial begin : result_sink
        int unsigned hold;
        i_out_stall = 1'b0;
        forever begin
            hold = idle_on ? $urandom_range(0, 17) : 0;
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            @(negedge i_clk);
        end
    end

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field,
                         want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every taken result with the oldest prediction.
    initial begin : result_checker
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("[%0t] result with no prediction pending", $realtime);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("cursor_row", want.pos.row, o_cursor_row);
                    check_field("cursor_col", want.pos.col, o_cursor_col);
                    check_field("cell_data", want.cell_data, o_cell_data);
                    check_field("written_count", want.count, o_written_count);
                    check_field("scrolled", want.scrolled, o_scrolled);
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        // Drive every input to a known value from time zero
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_TEXT_ATTR;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_PUT;
        i_char_code  = '0;
        i_last       = 1'b0;
        i_cell_index = '0;
        idle_on      = 1'b1;
        mismatch_count = 0;
        // Shadow console starts in the reset state
        for (i = 0; i < CELL_TOTAL; i++)
            screen_model[i] = '0;
        cur_row   = 0;
        cur_col   = 0;
        run_count = '0;
        attr_reg  = ATTR_RESET;
        blank_reg = BLANK_RESET;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The clearing pass after reset simply stalls the first transaction
        test_power_on_store();
        test_control_chars();
        test_text_phase(1'b0, ATTR_RESET, BLANK_RESET, 1'b1, 260);
        test_text_phase(1'b1, 8'h00, 16'h0000, 1'b1, 260);
        test_text_phase(1'b1, 8'hFF, 16'hFFFF, 1'b1, 260);
        test_text_phase(1'b1, ATTR_W'($urandom_range(0, 255)),
                        CELL_W'($urandom_range(0, 65535)), 1'b0, 270);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("text_console_writer_core regression: pass");
        else
            $display("text_console_writer_core regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_cursor.sv
rtl/text_console_writer_core.sv
verif/tb_text_console_writer_core.sv
